### hdl/token_bucket_pacer_with_reserve_macros.svh
// Assertion helpers shared by the pacer's RTL.
`ifndef TOKEN_BUCKET_PACER_WITH_RESERVE_MACROS_SVH
`define TOKEN_BUCKET_PACER_WITH_RESERVE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define TBP_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TBP_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

    // Field widths
    localparam int CAP_W        = 16;
    localparam int PCT_W        = 7;
    localparam int LEVEL_W      = 26;
    localparam int WAIT_W       = 11;
    localparam int CNT_OUT_W    = 32;
    localparam int FLOOR_UNIT_W = CAP_W + PCT_W;
    localparam int DIV_W        = LEVEL_W + 1;
    localparam int DIV_IDX_W    = 4;
    localparam int CFG_IDX_W    = 1;

    // Constants of the bucket arithmetic
    localparam logic [9:0]         MILLI      = 10'd1000;
    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd90;
    localparam logic [3:0]         PCT_SCALE  = 4'd10;
    localparam logic [CAP_W-1:0]   CAP_RESET  = 16'd10;
    localparam logic [PCT_W-1:0]   PCT_RESET  = 7'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 26'd65535000;
    localparam logic [WAIT_W-1:0]  WAIT_MAX   = 11'd1900;
    localparam logic [DIV_IDX_W-1:0] DIV_TOP  = 4'(WAIT_W - 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVE  = 1'b1;

    // Queue between the front and the engine
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_WAIT    = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CLS_ENTRY   = 2'd0,
        CLS_READ    = 2'd1,
        CLS_PROTECT = 2'd2
    } cls_t;

    // Decoded beat control, time travels beside it
    typedef struct packed {
        cmd_t cmd;
        cls_t cls;
        logic use_floor;
    } item_ctl_t;

    localparam int ITEM_CTL_W = $bits(item_ctl_t);

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [CNT_OUT_W-1:0] refused_protect_total;
        logic [CNT_OUT_W-1:0] refused_read_total;
        logic [CNT_OUT_W-1:0] refused_entry_total;
        logic [CNT_OUT_W-1:0] granted_total;
        logic [LEVEL_W-1:0]   level_milli;
        logic [WAIT_W-1:0]    wait_ms;
        logic                 granted;
    } result_t;

    localparam int RES_W     = $bits(result_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### hdl/tbp_queue.sv
`default_nettype none

module tbp_queue #(
    parameter int WIDTH = 51
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import tbp_pkg::*;

    logic [WIDTH-1:0]   mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store the beat at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/tbp_front.sv
`default_nettype none

module tbp_front #(
    parameter int TIME_BITS = 48,
    parameter int S_TDATA_W = 56
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output tbp_pkg::item_ctl_t        push_ctl,
    output logic [TIME_BITS-1:0]      push_now
);
    import tbp_pkg::*;

    logic                 valid_reg, valid_next;
    item_ctl_t            ctl_reg, ctl_dec;
    logic [TIME_BITS-1:0] now_reg;
    logic                 accept;

    assign s_axis_tready = !valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = valid_reg;
    assign push_ctl      = ctl_reg;
    assign push_now      = now_reg;

    // Classify the beat: unknown classes fall to protection
    always_comb begin
        ctl_dec.cmd = cmd_t'(s_axis_tdata[0]);
        case (s_axis_tdata[2:1])
            CLS_ENTRY: ctl_dec.cls = CLS_ENTRY;
            CLS_READ:  ctl_dec.cls = CLS_READ;
            default:   ctl_dec.cls = CLS_PROTECT;
        endcase
        ctl_dec.use_floor = (ctl_dec.cls inside {CLS_ENTRY, CLS_READ});
    end

    // Hold the decoded beat until the queue takes it
    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_reg <= ctl_dec;
            now_reg <= s_axis_tdata[TIME_BITS+2:3];
        end
    end

endmodule

`default_nettype wire

### hdl/tbp_engine.sv
`default_nettype none

module tbp_engine #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tbp_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire tbp_pkg::item_ctl_t           pop_ctl,
    input  wire logic [TIME_BITS-1:0]         pop_now,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output tbp_pkg::result_t                  res
);
    import tbp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SCALE,
        ST_LEVEL,
        ST_APPLY,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // Control and bucket state
    state_t                state_reg, state_next;
    logic                  res_valid_reg, res_valid_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [TIME_BITS-1:0]  last_reg, last_next;
    logic [COUNT_BITS-1:0] grant_cnt_reg, grant_cnt_next;
    logic [COUNT_BITS-1:0] ref_entry_reg, ref_entry_next;
    logic [COUNT_BITS-1:0] ref_read_reg, ref_read_next;
    logic [COUNT_BITS-1:0] ref_prot_reg, ref_prot_next;

    // Per-beat work registers
    item_ctl_t             ctl_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  now_gt_reg, dt_big_reg;
    logic [9:0]            dt_lo_reg;
    logic [LEVEL_W-1:0]    full_reg, floor_reg, add_reg, have_reg, target_reg;
    logic [FLOOR_UNIT_W-1:0] floor_unit_reg;
    logic [DIV_W-1:0]      num_reg, num_next;
    logic [DIV_IDX_W-1:0]  bit_reg, bit_next;
    logic [WAIT_W-1:0]     quot_reg, quot_next;
    logic                  granted_reg, granted_next;
    result_t               res_reg, res_next;

    // Combinational helpers
    logic [CAP_W-1:0]      eff_cap, cfg_cap;
    logic [PCT_W-1:0]      eff_pct;
    logic [TIME_BITS-1:0]  dt;
    logic [DIV_W-1:0]      level_sum, div_step;
    logic                  load_res;

    assign eff_cap   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign cfg_cap   = (cfg_wdata == '0) ? CAP_W'(1) : cfg_wdata;
    assign eff_pct   = (pct_reg > PCT_MAX) ? PCT_MAX : pct_reg;
    assign dt        = now_reg - last_reg;
    assign level_sum = {1'b0, level_reg} + {1'b0, add_reg};
    assign div_step  = DIV_W'(eff_cap) << bit_reg;
    assign load_res  = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);

    assign pop_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequence one beat, then apply configuration writes
    always_comb begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cap_next       = cap_reg;
        pct_next       = pct_reg;
        level_next     = level_reg;
        last_next      = last_reg;
        grant_cnt_next = grant_cnt_reg;
        ref_entry_next = ref_entry_reg;
        ref_read_next  = ref_read_reg;
        ref_prot_next  = ref_prot_reg;
        num_next       = num_reg;
        bit_next       = bit_reg;
        quot_next      = quot_reg;
        granted_next   = granted_reg;
        res_next       = res_reg;

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_LEVEL;
            ST_LEVEL: state_next = ST_APPLY;
            ST_APPLY: begin
                granted_next = 1'b0;
                quot_next    = '0;
                state_next   = ST_DONE;
                if (ctl_reg.cmd == CMD_ACQUIRE) begin
                    level_next = have_reg;
                    if (now_gt_reg) begin
                        last_next = now_reg;
                    end
                    if (have_reg >= target_reg) begin
                        level_next     = have_reg - LEVEL_W'(MILLI);
                        grant_cnt_next = (grant_cnt_reg == '1) ? grant_cnt_reg
                                                               : grant_cnt_reg + 1'b1;
                        granted_next   = 1'b1;
                    end else begin
                        case (ctl_reg.cls)
                            CLS_ENTRY: ref_entry_next = (ref_entry_reg == '1) ? ref_entry_reg
                                                        : ref_entry_reg + 1'b1;
                            CLS_READ:  ref_read_next = (ref_read_reg == '1) ? ref_read_reg
                                                       : ref_read_reg + 1'b1;
                            default:   ref_prot_next = (ref_prot_reg == '1) ? ref_prot_reg
                                                       : ref_prot_reg + 1'b1;
                        endcase
                    end
                end else if (target_reg > have_reg) begin
                    // Ceiling division: bias the numerator by capacity minus one
                    num_next   = DIV_W'(target_reg - have_reg) + DIV_W'(eff_cap) - 1'b1;
                    bit_next   = DIV_TOP;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // One quotient bit per cycle, most significant first
                if (num_reg >= div_step) begin
                    num_next            = num_reg - div_step;
                    quot_next[bit_reg]  = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_DONE: begin
                if (load_res) begin
                    res_next.granted               = granted_reg;
                    res_next.wait_ms               = quot_reg;
                    res_next.level_milli           = level_reg;
                    res_next.granted_total         = CNT_OUT_W'(grant_cnt_reg);
                    res_next.refused_entry_total   = CNT_OUT_W'(ref_entry_reg);
                    res_next.refused_read_total    = CNT_OUT_W'(ref_read_reg);
                    res_next.refused_protect_total = CNT_OUT_W'(ref_prot_reg);
                    res_valid_next                 = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Capacity write refills the bucket to full
        if (cfg_we) begin
            if (cfg_index == REG_CAPACITY) begin
                cap_next   = cfg_wdata;
                level_next = LEVEL_W'(cfg_cap) * LEVEL_W'(MILLI);
            end else begin
                pct_next = cfg_wdata[PCT_W-1:0];
            end
        end
    end

    // Hold state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            pct_reg       <= PCT_RESET;
            level_reg     <= LEVEL_W'(CAP_RESET) * LEVEL_W'(MILLI);
            last_reg      <= '0;
            grant_cnt_reg <= '0;
            ref_entry_reg <= '0;
            ref_read_reg  <= '0;
            ref_prot_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cap_reg       <= cap_next;
            pct_reg       <= pct_next;
            level_reg     <= level_next;
            last_reg      <= last_next;
            grant_cnt_reg <= grant_cnt_next;
            ref_entry_reg <= ref_entry_next;
            ref_read_reg  <= ref_read_next;
            ref_prot_reg  <= ref_prot_next;
        end
        res_reg     <= res_next;
        num_reg     <= num_next;
        bit_reg     <= bit_next;
        quot_reg    <= quot_next;
        granted_reg <= granted_next;
    end

    // Datapath stages of the refill and floor math
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ctl_reg <= pop_ctl;
                now_reg <= pop_now;
            end
            ST_DELTA: begin
                now_gt_reg     <= (now_reg > last_reg);
                dt_big_reg     <= (|dt[TIME_BITS-1:10]) || (dt[9:0] >= MILLI);
                dt_lo_reg      <= dt[9:0];
                full_reg       <= LEVEL_W'(eff_cap) * LEVEL_W'(MILLI);
                floor_unit_reg <= FLOOR_UNIT_W'(eff_cap) * FLOOR_UNIT_W'(eff_pct);
            end
            ST_SCALE: begin
                add_reg   <= LEVEL_W'(dt_lo_reg) * LEVEL_W'(eff_cap);
                floor_reg <= ctl_reg.use_floor
                           ? LEVEL_W'(floor_unit_reg) * LEVEL_W'(PCT_SCALE) : '0;
            end
            ST_LEVEL: begin
                target_reg <= floor_reg + LEVEL_W'(MILLI);
                if (last_reg == '0 || !now_gt_reg) begin
                    have_reg <= level_reg;
                end else if (dt_big_reg || level_sum > DIV_W'(full_reg)) begin
                    have_reg <= full_reg;
                end else begin
                    have_reg <= level_sum[LEVEL_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hdl/token_bucket_pacer_with_reserve.sv
`default_nettype none
`include "token_bucket_pacer_with_reserve_macros.svh"

// Token bucket pacer with a protected reserve, in milli-token fixed point.
// Each input beat is decoded and parked in a four-deep queue, so the slave
// side keeps taking beats while the engine works and while a result waits
// on the master side, as long as the queue has room. The engine handles one
// beat at a time: an acquire, or a wait query that needs no wait, passes
// through pop, three refill and floor stages, apply and result load; a wait
// query that must compute a delay also passes through the serial divider
// that yields one quotient bit of the ceiling division per cycle.
// Config writes are registered; a capacity write refills the bucket to full.
module token_bucket_pacer_with_reserve #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [tbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tbp_pkg::CAP_W-1:0]          cfg_wdata,
    // Request beats
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: command, request_class, now_ms, zero pad
    input  wire logic [((TIME_BITS + 10) / 8) * 8 - 1:0] s_axis_tdata,
    // Result beats
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: granted, wait_ms, level_milli, granted_total,
    // refused_entry_total, refused_read_total, refused_protect_total, zero pad
    output logic [tbp_pkg::M_TDATA_W-1:0]           m_axis_tdata
);
    import tbp_pkg::*;

    localparam int S_TDATA_W = ((TIME_BITS + 10) / 8) * 8;
    localparam int Q_W       = ITEM_CTL_W + TIME_BITS;

    logic                 push_valid, push_ready, pop_valid, pop_ready;
    item_ctl_t            push_ctl;
    logic [TIME_BITS-1:0] push_now;
    logic [Q_W-1:0]       pop_data;
    result_t              res;

    // Accept and classify
    tbp_front #(
        .TIME_BITS (TIME_BITS),
        .S_TDATA_W (S_TDATA_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_ctl      (push_ctl),
        .push_now      (push_now)
    );

    // Decouple front from engine
    tbp_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctl, push_now}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Refill, grant and wait computation
    tbp_engine #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_ctl   (item_ctl_t'(pop_data[Q_W-1:TIME_BITS])),
        .pop_now   (pop_data[TIME_BITS-1:0]),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {(M_TDATA_W - RES_W)'(0), res};

    // Result sanity and front stall check
    `TBP_ASSERT_IMPLIES(a_wait_range, m_axis_tvalid, res.wait_ms <= WAIT_MAX, "wait_ms out of range")
    `TBP_ASSERT_IMPLIES(a_grant_no_wait, m_axis_tvalid && res.granted, res.wait_ms == '0, "granted result carries a wait")
    `TBP_ASSERT_IMPLIES(a_level_cap, m_axis_tvalid, res.level_milli <= LEVEL_MAX, "level above full bucket")
    `TBP_ASSERT_IMPLIES(a_front_stall, push_valid && !push_ready, !s_axis_tready, "beat taken while queue full")

endmodule

`default_nettype wire

### bench/token_bucket_pacer_with_reserve_test.sv
`timescale 1ns / 100ps

module token_bucket_pacer_with_reserve_test;
    import tbp_pkg::*;

    localparam int TIME_W      = 48;
    localparam int REQ_W       = ((TIME_W + 10) / 8) * 8;
    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 75;
    localparam int PRINT_LIMIT = 100;

    typedef enum logic {
        ROW_REG,
        ROW_BEAT
    } row_kind_t;

    // One line of the directed plan; pinned rows carry hand-derived results
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CAP_W-1:0]       val;
        cmd_t                   cmd;
        logic [1:0]             cls;
        logic [TIME_W-1:0]      now;
        bit                     pinned;
        bit                     granted;
        int unsigned            wait_ms;
        int unsigned            level;
    } plan_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CAP_W-1:0]        cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata: command, request_class, now_ms, zero pad
    logic [REQ_W-1:0]        s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata: granted, wait_ms, level_milli, granted_total, refused_entry_total,
    // refused_read_total, refused_protect_total, zero pad
    logic [M_TDATA_W-1:0]    m_axis_tdata;

    // Shadow of the bucket
    logic [CAP_W-1:0]        cap_reg = CAP_RESET;
    logic [PCT_W-1:0]        pct_reg = PCT_RESET;
    logic [63:0]             level_mt = 64'd10000;
    logic [TIME_W-1:0]       last_ms = '0;
    logic [CNT_OUT_W-1:0]    grants = '0;
    logic [CNT_OUT_W-1:0]    refusals [3] = '{default: '0};

    result_t                 pending_results [$];
    plan_row_t               plan [$];
    int unsigned             errors = 0;
    int unsigned             results_seen = 0;
    int unsigned             idle_cycles = 0;
    int unsigned             rx_left = 0;
    bit                      quiet_tx = 1'b0;
    bit                      quiet_rx = 1'b0;
    result_t                 seen_beat;
    result_t                 due_beat;

    token_bucket_pacer_with_reserve dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Bucket arithmetic
    function automatic logic [63:0] unit_cap();
        return (cap_reg == 0) ? 64'd1 : 64'(cap_reg);
    endfunction

    function automatic logic [63:0] refill_view(logic [TIME_W-1:0] now);
        logic [63:0] full;
        logic [63:0] dt;
        logic [63:0] lvl;
        full = unit_cap() * MILLI;
        if (last_ms == 0 || now <= last_ms) return level_mt;
        dt = 64'(now) - 64'(last_ms);
        if (dt >= MILLI) return full;
        lvl = level_mt + dt * unit_cap();
        return (lvl > full) ? full : lvl;
    endfunction

    function automatic logic [63:0] floor_of(logic [1:0] cls);
        logic [63:0] pct;
        pct = (pct_reg > PCT_MAX) ? 64'(PCT_MAX) : 64'(pct_reg);
        if (cls == CLS_ENTRY || cls == CLS_READ) return unit_cap() * pct * PCT_SCALE;
        return 64'd0;
    endfunction

    function automatic logic [CNT_OUT_W-1:0] bump(logic [CNT_OUT_W-1:0] n);
        return (n == '1) ? n : n + 1'b1;
    endfunction

    // Apply one request to the shadow and return the result it should give
    function automatic result_t bucket_step(cmd_t cmd, logic [1:0] cls,
                                            logic [TIME_W-1:0] now);
        result_t     res;
        logic [63:0] have;
        logic [63:0] target;
        logic [63:0] wait_v;
        int          slot;
        wait_v = 0;
        res.granted = 1'b0;
        if (cmd == CMD_ACQUIRE) begin
            level_mt = refill_view(now);
            if (now > last_ms) last_ms = now;
            if (level_mt >= floor_of(cls) + MILLI) begin
                level_mt = level_mt - MILLI;
                grants = bump(grants);
                res.granted = 1'b1;
            end else begin
                slot = (cls == CLS_ENTRY) ? 0 : (cls == CLS_READ) ? 1 : 2;
                refusals[slot] = bump(refusals[slot]);
            end
        end else begin
            have = refill_view(now);
            target = floor_of(cls) + MILLI;
            if (target > have) wait_v = (target - have + unit_cap() - 1) / unit_cap();
        end
        res.wait_ms = wait_v[WAIT_W-1:0];
        res.level_milli = level_mt[LEVEL_W-1:0];
        res.granted_total = grants;
        res.refused_entry_total = refusals[0];
        res.refused_read_total = refusals[1];
        res.refused_protect_total = refusals[2];
        return res;
    endfunction

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t result %0d %s: got %0d, want %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_CAPACITY) begin
            cap_reg = val;
            level_mt = unit_cap() * MILLI;
        end else begin
            pct_reg = val[PCT_W-1:0];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offer one request beat and record its expected result once taken
    task automatic send_beat(cmd_t cmd, logic [1:0] cls, logic [TIME_W-1:0] now,
                             bit pinned, bit granted, int unsigned wait_ms,
                             int unsigned level);
        int unsigned gap;
        result_t     want;
        gap = pick_gap(quiet_tx);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= REQ_W'({now, cls, cmd});
        do @(posedge aclk); while (!s_axis_tready);
        want = bucket_step(cmd, cls, now);
        if (pinned) begin
            want.granted = granted;
            want.wait_ms = WAIT_W'(wait_ms);
            want.level_milli = LEVEL_W'(level);
        end
        pending_results.push_back(want);
    endtask

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] val);
        plan_row_t row;
        row = '{ROW_REG, idx, val, CMD_ACQUIRE, 2'd0, '0, 1'b0, 1'b0, 0, 0};
        return row;
    endfunction

    function automatic plan_row_t beat_row(cmd_t cmd, logic [1:0] cls, logic [TIME_W-1:0] now);
        plan_row_t row;
        row = '{ROW_BEAT, REG_CAPACITY, '0, cmd, cls, now, 1'b0, 1'b0, 0, 0};
        return row;
    endfunction

    function automatic plan_row_t pinned_row(cmd_t cmd, logic [1:0] cls,
                                             logic [TIME_W-1:0] now, bit granted,
                                             int unsigned wait_ms, int unsigned level);
        plan_row_t row;
        row = '{ROW_BEAT, REG_CAPACITY, '0, cmd, cls, now, 1'b1, granted, wait_ms, level};
        return row;
    endfunction

    // Result side: random stalls on tready, with stall-free stretches
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            if (quiet_rx || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                rx_left = $urandom_range(1, 12);
            end else begin
                m_axis_tready <= 1'b0;
                rx_left = pick_gap(1'b0) + 1;
            end
        end else begin
            rx_left = rx_left - 1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            seen_beat = result_t'(m_axis_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                flag_error("beat with nothing expected", seen_beat.level_milli, 0);
            end else begin
                due_beat = pending_results.pop_front();
                if (seen_beat.granted !== due_beat.granted)
                    flag_error("granted", seen_beat.granted, due_beat.granted);
                if (seen_beat.wait_ms !== due_beat.wait_ms)
                    flag_error("wait_ms", seen_beat.wait_ms, due_beat.wait_ms);
                if (seen_beat.level_milli !== due_beat.level_milli)
                    flag_error("level_milli", seen_beat.level_milli, due_beat.level_milli);
                if (seen_beat.granted_total !== due_beat.granted_total)
                    flag_error("granted_total", seen_beat.granted_total,
                               due_beat.granted_total);
                if (seen_beat.refused_entry_total !== due_beat.refused_entry_total)
                    flag_error("refused_entry_total", seen_beat.refused_entry_total,
                               due_beat.refused_entry_total);
                if (seen_beat.refused_read_total !== due_beat.refused_read_total)
                    flag_error("refused_read_total", seen_beat.refused_read_total,
                               due_beat.refused_read_total);
                if (seen_beat.refused_protect_total !== due_beat.refused_protect_total)
                    flag_error("refused_protect_total", seen_beat.refused_protect_total,
                               due_beat.refused_protect_total);
            end
        end
    end

    // Abort when neither side has moved a beat for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] now;
        logic [1:0]        cls;
        cmd_t              cmd;
        int unsigned       r;
        int unsigned       span;
        logic [63:0]       back;

        // Directed: reset state, class floors, reserve and capacity extremes
        plan.push_back(pinned_row(CMD_WAIT, CLS_ENTRY, 48'd0, 1'b0, 0, 10000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_ENTRY, 48'd0, 1'b1, 0, 9000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_READ, 48'd5, 1'b1, 0, 8000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_PROTECT, 48'd5, 1'b1, 0, 7000));
        // unknown class in the past: treated as protection, no refill
        plan.push_back(pinned_row(CMD_ACQUIRE, 2'd3, 48'd4, 1'b1, 0, 6000));
        plan.push_back(beat_row(CMD_ACQUIRE, CLS_ENTRY, 48'd6));
        plan.push_back(beat_row(CMD_WAIT, CLS_READ, 48'd6));
        plan.push_back(reg_row(REG_CAPACITY, 16'd1));
        // reserve above the cap acts as the cap
        plan.push_back(reg_row(REG_RESERVE, 16'd127));
        plan.push_back(pinned_row(CMD_WAIT, CLS_ENTRY, 48'd6, 1'b0, 900, 1000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_ENTRY, 48'd6, 1'b0, 0, 1000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_READ, 48'd6, 1'b0, 0, 1000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_PROTECT, 48'd6, 1'b1, 0, 0));
        plan.push_back(pinned_row(CMD_WAIT, CLS_ENTRY, 48'd6, 1'b0, 1900, 0));
        plan.push_back(pinned_row(CMD_ACQUIRE, 2'd3, 48'd6, 1'b0, 0, 0));
        plan.push_back(pinned_row(CMD_WAIT, CLS_PROTECT, 48'd7, 1'b0, 999, 0));
        // zero capacity acts as one token per second
        plan.push_back(reg_row(REG_CAPACITY, 16'd0));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_PROTECT, 48'd2000, 1'b1, 0, 0));
        plan.push_back(reg_row(REG_CAPACITY, 16'hFFFF));
        plan.push_back(reg_row(REG_RESERVE, 16'd90));
        plan.push_back(pinned_row(CMD_WAIT, CLS_ENTRY, '1, 1'b0, 0, 65535000));
        plan.push_back(pinned_row(CMD_ACQUIRE, CLS_ENTRY, 48'd2500, 1'b1, 0, 65534000));
        plan.push_back(beat_row(CMD_WAIT, CLS_READ, 48'd1));
        plan.push_back(beat_row(CMD_ACQUIRE, CLS_READ, 48'd0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_beat(plan[i].cmd, plan[i].cls, plan[i].now, plan[i].pinned,
                          plan[i].granted, plan[i].wait_ms, plan[i].level);
            end
        end

        // Random phases, each under its own capacity and reserve
        for (int p = 0; p < PHASES; p++) begin
            r = $urandom_range(0, 4);
            case (r)
                0: write_reg(REG_CAPACITY, 16'd0);
                1: write_reg(REG_CAPACITY, 16'd1);
                2: write_reg(REG_CAPACITY, 16'($urandom_range(2, 40)));
                3: write_reg(REG_CAPACITY, 16'($urandom_range(41, 65535)));
                default: write_reg(REG_CAPACITY, 16'hFFFF);
            endcase
            r = $urandom_range(0, 3);
            case (r)
                0: write_reg(REG_RESERVE, 16'd0);
                1: write_reg(REG_RESERVE, 16'd90);
                2: write_reg(REG_RESERVE, 16'd127);
                default: write_reg(REG_RESERVE, 16'($urandom_range(0, 127)));
            endcase
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            span = 32'(2000 / unit_cap());

            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 1 && n == PHASE_BEATS / 2) drain_results();
                r = $urandom_range(0, 9);
                cls = (r < 3) ? 2'd0 : (r < 6) ? 2'd1 : (r < 9) ? 2'd2 : 2'd3;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // time moves forward in steps sized to drain the bucket
                    cmd = ($urandom_range(0, 3) == 0) ? CMD_WAIT : CMD_ACQUIRE;
                    r = $urandom_range(0, 9);
                    if (r == 0) now = last_ms;
                    else if (r < 8) now = last_ms + $urandom_range(0, span);
                    else if (r < 9) now = last_ms + $urandom_range(0, 200);
                    else now = last_ms + $urandom_range(1000, 3000);
                end else if (r < 80) begin
                    // any time at all, on a query so the clock is not pushed
                    cmd = CMD_WAIT;
                    now = {16'($urandom), $urandom};
                end else if (r < 88) begin
                    cmd = CMD_ACQUIRE;
                    now = '0;
                end else if (r < 95) begin
                    cmd = CMD_ACQUIRE;
                    back = (last_ms > 50) ? 64'd50 : 64'(last_ms);
                    now = last_ms - TIME_W'($urandom_range(0, 32'(back)));
                end else begin
                    cmd = CMD_WAIT;
                    now = last_ms;
                end
                send_beat(cmd, cls, now, 1'b0, 1'b0, 0, 0);
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### token_bucket_pacer_with_reserve.f
+incdir+hdl
hdl/tbp_pkg.sv
hdl/tbp_queue.sv
hdl/tbp_front.sv
hdl/tbp_engine.sv
hdl/token_bucket_pacer_with_reserve.sv
bench/token_bucket_pacer_with_reserve_test.sv
